// ----- hw/rtl/sdep_pkg.sv -----
// sdep_pkg: types and constants for the SSE data-event parser.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none
package sdep_pkg;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_PREFIX = 3'd1,
    MODE_SKIP   = 3'd2,
    MODE_DATA   = 3'd3,
    MODE_IGNORE = 3'd4
  } line_mode_t;

  typedef enum logic {
    REQ_BYTE  = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } out_kind_t;

  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [2:0] PREFIX_LEN = 3'd5;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    line_mode_t  mode;
    logic [2:0]  prefix_matched;
    logic        cr_held;
    logic        has_lines;
  } parse_st_t;

  typedef struct packed {
    logic [0:0]  out_kind;
    logic [7:0]  out_byte;
    logic        last;
  } result_t;

  // "data:" tag byte at a given match position
  function automatic logic [7:0] tag_byte(input logic [2:0] pos);
    logic [7:0] t;
    case (pos)
      3'd0:    t = 8'h64;
      3'd1:    t = 8'h61;
      3'd2:    t = 8'h74;
      3'd3:    t = 8'h61;
      3'd4:    t = 8'h3A;
      default: t = 8'h00;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sdep_if.sv -----
// sdep_in_if / sdep_out_if: valid/ready channels of the SSE parser.
// Imports sdep_pkg; the field widths are given as literals.
`default_nettype none
interface sdep_in_if import sdep_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [0:0] req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

interface sdep_out_if import sdep_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [0:0] out_kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_kind, output out_byte, output last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input last,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sse_data_event_parser_unit.sv -----
// sse_data_event_parser_unit: SSE data-line parser, one byte per transfer.
// Depends on sdep_pkg and the channel interfaces in sdep_if.sv.
//
// channel  dir  payload                       notes
// in_ch    in   req_type[0:0], in_byte[7:0]   byte or end-of-stream flush
// out_ch   out  out_kind[0:0], out_byte[7:0], last   0..2 results per input
//
// One input per cycle while in_ch.ready is high: parse state updates in the
// accepting cycle and up to two results are written into a 4-entry result FIFO.
// Results appear on out_ch in the cycle after the input transfer at the earliest.
// in_ch.ready is high while the FIFO has room for two results.
// Synchronous active-high reset clears parse state and the FIFO pointers.
`default_nettype none
module sse_data_event_parser_unit
  import sdep_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  sdep_in_if.sink     in_ch,
  sdep_out_if.source  out_ch
);

  typedef struct packed {
    parse_st_t   st;
    logic        emit;
    logic [7:0]  data;
  } lb_res_t;

  function automatic lb_res_t line_byte(input parse_st_t s, input logic [7:0] b);
    lb_res_t r;
    r.st   = s;
    r.emit = 1'b0;
    r.data = b;
    case (s.mode)
      MODE_START: begin
        if (b == tag_byte(3'd0)) begin
          r.st.mode           = MODE_PREFIX;
          r.st.prefix_matched = 3'd1;
        end else begin
          r.st.mode = MODE_IGNORE;
        end
      end
      MODE_PREFIX: begin
        if (s.prefix_matched < PREFIX_LEN && b == tag_byte(s.prefix_matched)) begin
          r.st.prefix_matched = s.prefix_matched + 3'd1;
          if (r.st.prefix_matched == PREFIX_LEN) begin
            r.emit         = s.has_lines;
            r.data         = BYTE_LF;
            r.st.has_lines = 1'b1;
            r.st.mode      = MODE_SKIP;
          end
        end else begin
          r.st.mode = MODE_IGNORE;
        end
      end
      MODE_SKIP: begin
        if (b != BYTE_SPACE) begin
          r.emit    = 1'b1;
          r.st.mode = MODE_DATA;
        end
      end
      MODE_DATA: begin
        r.emit = 1'b1;
      end
      default: begin
        r.st.mode = MODE_IGNORE;
      end
    endcase
    return r;
  endfunction

  localparam parse_st_t ST_RESET = '{mode: MODE_START, prefix_matched: 3'd0,
                                     cr_held: 1'b0, has_lines: 1'b0};

  parse_st_t st, st_next;

  result_t            fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;

  logic        in_xfer, out_xfer;
  logic [1:0]  n_res;
  result_t     res0, res1;

  assign in_ch.ready = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_ch.valid && out_ch.ready;

  always_comb begin
    parse_st_t s;
    lb_res_t   a, c;
    logic      e0, e1;
    logic [7:0] d0, d1;
    st_next = st;
    n_res   = 2'd0;
    res0    = '{out_kind: KIND_DATA, out_byte: 8'h00, last: 1'b1};
    res1    = '{out_kind: KIND_DATA, out_byte: 8'h00, last: 1'b1};
    s  = st;
    a  = '0;
    c  = '0;
    e0 = 1'b0;
    e1 = 1'b0;
    d0 = 8'h00;
    d1 = 8'h00;
    if (in_ch.req_type == REQ_FLUSH) begin
      if (st.has_lines) begin
        n_res         = 2'd1;
        res0.out_kind = KIND_END;
      end
      st_next = ST_RESET;
    end else if (in_ch.in_byte == BYTE_LF) begin
      if (st.mode == MODE_START && st.has_lines) begin
        n_res             = 2'd1;
        res0.out_kind     = KIND_END;
        st_next.has_lines = 1'b0;
      end
      st_next.cr_held        = 1'b0;
      st_next.mode           = MODE_START;
      st_next.prefix_matched = 3'd0;
    end else begin
      s.cr_held = 1'b0;
      if (st.cr_held) begin
        a  = line_byte(s, BYTE_CR);
        s  = a.st;
        e0 = a.emit;
        d0 = a.data;
      end
      if (in_ch.in_byte == BYTE_CR) begin
        s.cr_held = 1'b1;
      end else begin
        c  = line_byte(s, in_ch.in_byte);
        s  = c.st;
        e1 = c.emit;
        d1 = c.data;
      end
      st_next = s;
      if (e0 && e1) begin
        n_res         = 2'd2;
        res0.out_byte = d0;
        res0.last     = 1'b0;
        res1.out_byte = d1;
      end else if (e0 || e1) begin
        n_res         = 2'd1;
        res0.out_byte = e0 ? d0 : d1;
      end
    end
  end

  assign count_next = count + CNT_W'(in_xfer ? n_res : 2'd0)
                    - CNT_W'(out_xfer);

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= ST_RESET;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_xfer) begin
        st     <= st_next;
        wr_ptr <= wr_ptr + PTR_W'(n_res);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && n_res != 2'd0) begin
      fifo[wr_ptr] <= res0;
    end
    if (in_xfer && n_res == 2'd2) begin
      fifo[wr_ptr + PTR_W'(1)] <= res1;
    end
  end

  assign out_ch.valid    = (count != '0);
  assign out_ch.out_kind = fifo[rd_ptr].out_kind;
  assign out_ch.out_byte = fifo[rd_ptr].out_byte;
  assign out_ch.last     = fifo[rd_ptr].last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result FIFO overflow");

  a_flush_resets: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_ch.req_type == REQ_FLUSH |=> st == ST_RESET)
    else $error("flush did not return parse state to reset");

  a_lf_line_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_ch.req_type == REQ_BYTE && in_ch.in_byte == BYTE_LF
    |=> st.mode == MODE_START && st.prefix_matched == 3'd0 && !st.cr_held)
    else $error("LF did not restart the line");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_xfer && n_res != 2'd0 && res0.out_kind == KIND_END |=> !st.has_lines)
    else $error("end of event left event open");

endmodule
`default_nettype wire
